// ===== rtl/psps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the paired-strand peak search block.
// Depends on nothing; the scan cell and the top level refer to it by scoped names.
package psps_pkg;

  // Widths of the item fields and configuration registers.
  localparam int unsigned CntW   = 16;
  localparam int unsigned ChromW = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned BsizeW = 11;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SHIFT_START = 2'd0,
    REG_SHIFT_END   = 2'd1,
    REG_BIN_SIZE    = 2'd2,
    REG_CUTOFF      = 2'd3
  } reg_idx_e;

  // Rotation step of a scan cell: which neighbour it copies from.
  typedef enum logic [1:0] {
    MV_HOLD  = 2'd0,
    MV_NEXT  = 2'd1,
    MV_PREV  = 2'd2,
    MV_PREV2 = 2'd3
  } move_e;

  // One input beat.
  typedef struct packed {
    logic [CntW-1:0]   plus_count;
    logic [CntW-1:0]   minus_count;
    logic              first_of_chrom;
    logic [ChromW-1:0] chrom_index;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [ChromW-1:0] chrom_tag;
    logic [CoordW-1:0] region_start;
    logic [CoordW-1:0] region_end;
    logic              divergent;
    logic              plus_strand;
    logic [CntW-1:0]   pair_plus_count;
    logic [CntW-1:0]   pair_minus_count;
  } out_item_t;

endpackage

// ===== rtl/psps_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is given per instance, normally a struct of psps_pkg.
interface psps_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/psps_win_cell.sv =====
`timescale 1ns / 1ps
// One bin of the sliding window: holds a plus/minus count pair.
// Uses no package items; instantiated in a row by the top level.
module psps_win_cell #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  logic         clear_i,
  input  logic [W-1:0] in_i,
  output logic [W-1:0] val_o
);
  logic [W-1:0] val_d, val_q;

  // Take the neighbour's bin on a new beat, or zero on a chromosome restart.
  always_comb begin
    val_d = val_q;
    if (shift_i) begin
      val_d = clear_i ? '0 : in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
endmodule

// ===== rtl/psps_scan_cell.sv =====
`timescale 1ns / 1ps
// One cell of a rotating scan ring: copies a window bin, then rotates.
// Depends on psps_pkg for the move code.
module psps_scan_cell #(
  parameter int unsigned W = 16
) (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic [W-1:0]    load_val_i,
  input  psps_pkg::move_e move_i,
  input  logic [W-1:0]    nxt_i,
  input  logic [W-1:0]    prv_i,
  input  logic [W-1:0]    prv2_i,
  output logic [W-1:0]    val_o
);
  logic [W-1:0] val_d, val_q;

  // Load a snapshot of the window, or copy from a neighbour to rotate the ring.
  always_comb begin
    val_d = val_q;
    if (load_i) begin
      val_d = load_val_i;
    end else begin
      unique case (move_i)
        psps_pkg::MV_HOLD:  val_d = val_q;
        psps_pkg::MV_NEXT:  val_d = nxt_i;
        psps_pkg::MV_PREV:  val_d = prv_i;
        psps_pkg::MV_PREV2: val_d = prv2_i;
        default:            val_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
endmodule

// ===== rtl/paired_strand_peak_search_top.sv =====
`timescale 1ns / 1ps
// Paired-strand peak search top level: window, scan rings and control.
// Depends on psps_pkg, psps_stream_if, psps_win_cell and psps_scan_cell.

// Each accepted bin beat shifts into a row of 2*MAX_LIM+1 window cells. Once
// enough bins of the chromosome have arrived, the window is copied into two
// rotating rings of cells (plus and minus counts) and the shifts are scanned
// one per cycle at the ring heads. An evaluating item loads the rings, then
// rotates them to the first shift, whose plus and minus bins lie at window
// offsets of at most 3*lim/2, compares each shift in [shift_start_bins,
// shift_end_bins), then waits for a free output register and forms the
// coordinates. A result waits in an output register, so the next bin is
// taken while it is still held.
module paired_strand_peak_search_top #(
  parameter int unsigned MAX_LIM    = 48,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psps_pkg::CfgW-1:0]      cfg_data_i,
  psps_stream_if.sink                    in_i,
  psps_stream_if.source                  out_o
);
  localparam int unsigned N    = 2 * MAX_LIM + 1;
  localparam int unsigned IW   = $clog2(N);
  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned PW   = 2 * (CW + 1);
  localparam int unsigned SW   = 12;
  localparam int unsigned CMPW = (CW > psps_pkg::CntW) ? CW : psps_pkg::CntW;
  localparam int unsigned KW   = psps_pkg::CoordW;
  localparam int unsigned MW   = KW + psps_pkg::BsizeW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ALIGN = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_MUL   = 6'b100000
  } state_e;

  // Configuration registers.
  logic [psps_pkg::ShiftW-1:0] ss_cfg_q, se_cfg_q;
  logic [psps_pkg::BsizeW-1:0] bsize_q;
  logic [psps_pkg::CntW-1:0]   cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_cfg_q <= 7'h50;
      se_cfg_q <= 7'h30;
      bsize_q  <= 11'd5;
      cutoff_q <= 16'd5;
    end else if (cfg_we_i) begin
      unique case (psps_pkg::reg_idx_e'(cfg_idx_i))
        psps_pkg::REG_SHIFT_START: ss_cfg_q <= cfg_data_i[psps_pkg::ShiftW-1:0];
        psps_pkg::REG_SHIFT_END:   se_cfg_q <= cfg_data_i[psps_pkg::ShiftW-1:0];
        psps_pkg::REG_BIN_SIZE:    bsize_q  <= cfg_data_i[psps_pkg::BsizeW-1:0];
        psps_pkg::REG_CUTOFF:      cutoff_q <= cfg_data_i;
        default:                   ;
      endcase
    end
  end

  // Shift range clamped to the window, and the window half-width lim.
  function automatic logic signed [SW-1:0] clamp_shift(input logic [psps_pkg::ShiftW-1:0] s);
    logic signed [SW-1:0] v;
    v = SW'($signed(s));
    if (v < -$signed(SW'(MAX_LIM))) begin
      v = -$signed(SW'(MAX_LIM));
    end else if (v > $signed(SW'(MAX_LIM))) begin
      v = $signed(SW'(MAX_LIM));
    end
    return v;
  endfunction

  // Shift j halved with truncation toward zero.
  function automatic logic signed [SW-1:0] half_of(input logic signed [SW-1:0] j);
    logic signed [SW-1:0] t;
    t = j + ((j < 0) ? SW'(1) : SW'(0));
    return t >>> 1;
  endfunction

  logic signed [SW-1:0] ss, se, lim;
  assign ss  = clamp_shift(ss_cfg_q);
  assign se  = clamp_shift(se_cfg_q);
  always_comb begin
    lim = (-ss > se) ? -ss : se;
    if (lim < 0) begin
      lim = '0;
    end
  end

  // Window offsets (back from the newest bin) of the plus and minus bins of a shift.
  function automatic logic signed [SW-1:0] plus_back(input logic signed [SW-1:0] j,
                                                     input logic signed [SW-1:0] l);
    return l - half_of(j) - SW'(j[0]);
  endfunction

  function automatic logic signed [SW-1:0] minus_back(input logic signed [SW-1:0] j,
                                                      input logic signed [SW-1:0] l);
    return l + half_of(j);
  endfunction

  // Control registers.
  state_e                state_q, state_d;
  logic [KW-1:0]         cnt_q, cnt_d, k_q, k_d;
  logic [psps_pkg::ChromW-1:0] chrom_q, chrom_d, tag_q, tag_d;
  logic signed [SW-1:0]  j_q, j_d;
  logic [IW-1:0]         prot_q, prot_d, mrot_q, mrot_d;
  logic [PW-1:0]         best_q, best_d;
  logic                  found_q, found_d;
  logic signed [SW-1:0]  bpoff_q, bpoff_d, bmoff_q, bmoff_d;
  logic [CW-1:0]         bpc_q, bpc_d, bmc_q, bmc_d;
  logic [KW-1:0]         sidx_q, sidx_d, eidx_q, eidx_d;
  logic                  div_q, div_d, strand_q, strand_d;
  logic                  out_valid_q, out_valid_d;
  psps_pkg::out_item_t   out_q, out_d;

  logic                  in_acc;
  logic                  ring_load;
  psps_pkg::move_e       pmove, mmove;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  // Window row: cell 0 takes the new bin, each other cell its predecessor.
  logic [2*CW-1:0] win_val [N];
  logic [2*CW-1:0] new_bin;
  assign new_bin = {CW'(in_i.data.plus_count), CW'(in_i.data.minus_count)};

  // Scan rings of plus and minus counts.
  logic [CW-1:0] pval [N];
  logic [CW-1:0] mval [N];

  for (genvar i = 0; i < N; i++) begin : g_cells
    if (i == 0) begin : g_head
      psps_win_cell #(.W(2*CW)) u_win (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .clear_i (1'b0),
        .in_i    (new_bin),
        .val_o   (win_val[i])
      );
    end else begin : g_body
      psps_win_cell #(.W(2*CW)) u_win (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .clear_i (in_i.data.first_of_chrom),
        .in_i    (win_val[i-1]),
        .val_o   (win_val[i])
      );
    end

    psps_scan_cell #(.W(CW)) u_pring (
      .clk_i      (clk_i),
      .load_i     (ring_load),
      .load_val_i (win_val[i][2*CW-1:CW]),
      .move_i     (pmove),
      .nxt_i      (pval[(i + 1) % N]),
      .prv_i      (pval[(i + N - 1) % N]),
      .prv2_i     (pval[(i + N - 2) % N]),
      .val_o      (pval[i])
    );

    psps_scan_cell #(.W(CW)) u_mring (
      .clk_i      (clk_i),
      .load_i     (ring_load),
      .load_val_i (win_val[i][CW-1:0]),
      .move_i     (mmove),
      .nxt_i      (mval[(i + 1) % N]),
      .prv_i      (mval[(i + N - 1) % N]),
      .prv2_i     (mval[(i + N - 2) % N]),
      .val_o      (mval[i])
    );
  end

  // Targets for ring alignment and for the step to the next shift.
  logic signed [SW-1:0] tp0, tm0, jn, dp, dm;
  logic signed [SW-1:0] prot_s, mrot_s;
  assign tp0    = plus_back(ss, lim);
  assign tm0    = minus_back(ss, lim);
  assign jn     = j_q + SW'(1);
  assign prot_s = SW'({1'b0, prot_q});
  assign mrot_s = SW'({1'b0, mrot_q});
  assign dp     = plus_back(jn, lim) - prot_s;
  assign dm     = minus_back(jn, lim) - mrot_s;

  // Score of the pair at the ring heads.
  logic [CW-1:0] ph, mh;
  logic          pass;
  logic [PW-1:0] prod;
  assign ph   = pval[0];
  assign mh   = mval[0];
  assign pass = (CMPW'(ph) >= CMPW'(cutoff_q)) && (CMPW'(mh) >= CMPW'(cutoff_q));
  assign prod = PW'({1'b0, ph} + (CW+1)'(1)) * PW'({1'b0, mh} + (CW+1)'(1));

  // Paired bin indexes of the winner.
  logic signed [KW+1:0] bp_idx, bm_idx;
  assign bp_idx = $signed({2'b00, k_q}) - (KW+2)'(lim) + (KW+2)'(bpoff_q);
  assign bm_idx = $signed({2'b00, k_q}) - (KW+2)'(lim) + (KW+2)'(bmoff_q);

  // Coordinates: index times bin size, saturating.
  logic [MW-1:0] sprod, eprod;
  assign sprod = MW'(sidx_q) * MW'(bsize_q);
  assign eprod = MW'(eidx_q) * MW'(bsize_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    chrom_d     = chrom_q;
    tag_d       = tag_q;
    j_d         = j_q;
    prot_d      = prot_q;
    mrot_d      = mrot_q;
    best_d      = best_q;
    found_d     = found_q;
    bpoff_d     = bpoff_q;
    bmoff_d     = bmoff_q;
    bpc_d       = bpc_q;
    bmc_d       = bmc_q;
    sidx_d      = sidx_q;
    eidx_d      = eidx_q;
    div_d       = div_q;
    strand_d    = strand_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ring_load   = 1'b0;
    pmove       = psps_pkg::MV_HOLD;
    mmove       = psps_pkg::MV_HOLD;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.first_of_chrom) begin
            k_d     = '0;
            cnt_d   = KW'(1);
            chrom_d = in_i.data.chrom_index;
            tag_d   = in_i.data.chrom_index;
          end else begin
            k_d   = cnt_q;
            cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + KW'(1);
            tag_d = chrom_q;
          end
          if ((KW+1)'(k_d) >= (KW+1)'(lim <<< 1)) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        ring_load = 1'b1;
        prot_d    = '0;
        mrot_d    = '0;
        best_d    = PW'(1);
        found_d   = 1'b0;
        j_d       = ss;
        state_d   = (ss >= se) ? ST_IDLE : ST_ALIGN;
      end
      ST_ALIGN: begin
        if (prot_s < tp0) begin
          pmove  = psps_pkg::MV_NEXT;
          prot_d = prot_q + IW'(1);
        end
        if (mrot_s < tm0) begin
          mmove  = psps_pkg::MV_NEXT;
          mrot_d = mrot_q + IW'(1);
        end
        if (prot_s == tp0 && mrot_s == tm0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass && prod > best_q) begin
          best_d  = prod;
          found_d = 1'b1;
          bpoff_d = half_of(j_q) + SW'(j_q[0]);
          bmoff_d = -half_of(j_q);
          bpc_d   = ph;
          bmc_d   = mh;
        end
        if (jn == se) begin
          state_d = ST_DONE;
        end else begin
          j_d = jn;
          priority if (dp == SW'(1)) begin
            pmove = psps_pkg::MV_NEXT;
          end else if (dp == -SW'(1)) begin
            pmove = psps_pkg::MV_PREV;
          end else if (dp == -SW'(2)) begin
            pmove = psps_pkg::MV_PREV2;
          end else begin
            pmove = psps_pkg::MV_HOLD;
          end
          if (dm == SW'(1)) begin
            mmove = psps_pkg::MV_NEXT;
          end
          prot_d = prot_q + IW'(dp);
          mrot_d = mrot_q + IW'(dm);
        end
      end
      ST_DONE: begin
        if (!found_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q) begin
          div_d    = (bpoff_q > bmoff_q);
          strand_d = (bpc_q > bmc_q);
          sidx_d   = div_d ? bm_idx[KW-1:0] : bp_idx[KW-1:0];
          eidx_d   = div_d ? bp_idx[KW-1:0] : bm_idx[KW-1:0];
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        out_d.chrom_tag        = tag_q;
        out_d.region_start     = (sprod[MW-1:KW] != '0) ? '1 : sprod[KW-1:0];
        out_d.region_end       = (eprod[MW-1:KW] != '0) ? '1 : eprod[KW-1:0];
        out_d.divergent        = div_q;
        out_d.plus_strand      = strand_q;
        out_d.pair_plus_count  = psps_pkg::CntW'(bpc_q);
        out_d.pair_minus_count = psps_pkg::CntW'(bmc_q);
        out_valid_d            = 1'b1;
        state_d                = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chrom_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chrom_q     <= chrom_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    tag_q    <= tag_d;
    j_q      <= j_d;
    prot_q   <= prot_d;
    mrot_q   <= mrot_d;
    best_q   <= best_d;
    bpoff_q  <= bpoff_d;
    bmoff_q  <= bmoff_d;
    bpc_q    <= bpc_d;
    bmc_q    <= bmc_d;
    sidx_q   <= sidx_d;
    eidx_q   <= eidx_d;
    div_q    <= div_d;
    strand_q <= strand_d;
    out_q    <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // A result is only written into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> !out_valid_q)
    else $error("result written over a waiting beat");

  // Ring alignment never overshoots the first plus offset.
  a_align_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ALIGN |-> prot_s <= tp0)
    else $error("plus ring rotated past its first offset");

  // A new result appears only after the coordinate step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_MUL)
    else $error("result raised outside the coordinate step");
`endif
endmodule
